// ===== hdl/fvr_pkg.sv =====
// fvr_pkg: shared types, constants and helpers of the fan voltage regulator
// no dependencies; imported by every module of the block

package fvr_pkg;

  // fixed timing of the slot counter and the fuse no-load counter
  localparam logic [4:0] SLOT_PERIOD    = 5'd30;
  localparam logic [4:0] CUR_SLOT_FIRST = 5'd20;
  localparam logic [4:0] REG_SLOT_LAST  = 5'd10;
  localparam logic [6:0] NO_LOAD_LIMIT  = 7'd100;

  // over-current, over-voltage and no-load counter limits
  localparam logic [2:0] OC_MAX   = 3'd7;
  localparam logic [2:0] OC_FORCE = 3'd5;
  localparam logic [3:0] OV_MAX   = 4'd15;
  localparam logic [6:0] NL_MAX   = 7'd127;

  // forced duties under over-current
  localparam logic [7:0] DUTY_OC_HIGH = 8'd1;
  localparam logic [7:0] DUTY_OC_MID  = 8'd11;

  // start duties per mode
  localparam logic [7:0] DUTY_START_1 = 8'd5;
  localparam logic [7:0] DUTY_START_2 = 8'd8;
  localparam logic [7:0] DUTY_START_3 = 8'd11;

  // voltage windows for nudging
  localparam logic [11:0] V_LOW_GATE = 12'd100;
  localparam logic [11:0] V1_UP      = 12'd1200;
  localparam logic [11:0] V1_DN3     = 12'd1350;
  localparam logic [11:0] V1_DN1     = 12'd1280;
  localparam logic [11:0] V2_UP      = 12'd1550;
  localparam logic [11:0] V2_DN3     = 12'd1700;
  localparam logic [11:0] V2_DN1     = 12'd1630;
  localparam logic [11:0] V3_UP      = 12'd2100;
  localparam logic [11:0] V3_DN4     = 12'd2350;
  localparam logic [11:0] V3_DN2     = 12'd2250;
  localparam logic [11:0] V3_DN1     = 12'd2200;

  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_LOW = 2'd1,
    MODE_MID = 2'd2,
    MODE_TOP = 2'd3
  } fan_mode_t;

  typedef enum logic [2:0] {
    CFG_OVERVOLT_LEVEL   = 3'd0,
    CFG_OVERVOLT_RELEASE = 3'd1,
    CFG_OVERVOLT_LIMIT   = 3'd2,
    CFG_FUSE_HOLD        = 3'd3,
    CFG_CUR_LOW          = 3'd4,
    CFG_CUR_MID          = 3'd5,
    CFG_CUR_HIGH         = 3'd6,
    CFG_DUTY_CAP         = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [11:0] overvolt_level;
    logic [11:0] overvolt_release;
    logic [3:0]  overvolt_count_limit;
    logic [6:0]  fuse_hold_slots;
    logic [11:0] current_limit_low;
    logic [11:0] current_limit_mid;
    logic [11:0] current_limit_high;
    logic [7:0]  duty_cap_on;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    overvolt_level:       12'd2700,
    overvolt_release:     12'd2100,
    overvolt_count_limit: 4'd9,
    fuse_hold_slots:      7'd100,
    current_limit_low:    12'd300,
    current_limit_mid:    12'd400,
    current_limit_high:   12'd500,
    duty_cap_on:          8'd16
  };

  typedef struct packed {
    logic        key_press;
    logic [11:0] fan_voltage;
    logic [11:0] out_current;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic       fan_enable;
    logic [7:0] applied_duty;
    logic       fuse_trip;
  } out_item_t;

  typedef struct packed {
    fan_mode_t  fan_mode;
    logic [4:0] slot_counter;
    logic [7:0] target_duty;
    logic [7:0] duty_limit;
    logic [3:0] overvolt_count;
    logic [6:0] hold_countdown;
    logic [2:0] overcurrent_count;
    logic [6:0] no_load_count;
    logic       fan_on_reg;
    logic [7:0] duty_out_reg;
  } state_t;

  localparam state_t STATE_RESET = '{
    fan_mode:          MODE_OFF,
    slot_counter:      5'd0,
    target_duty:       8'd5,
    duty_limit:        8'd0,
    overvolt_count:    4'd0,
    hold_countdown:    7'd0,
    overcurrent_count: 3'd0,
    no_load_count:     7'd0,
    fan_on_reg:        1'b0,
    duty_out_reg:      8'd0
  };

  function automatic logic [7:0] start_duty(input fan_mode_t mode);
    logic [7:0] d;
    case (mode)
      MODE_LOW: d = DUTY_START_1;
      MODE_MID: d = DUTY_START_2;
      default:  d = DUTY_START_3;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/fvr_cfg.sv =====
// fvr_cfg: configuration register file of the fan voltage regulator
// depends on fvr_pkg for the register layout, indexes and reset values

module fvr_cfg import fvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_OVERVOLT_LEVEL:   cfg_nxt.overvolt_level       = cfg_wdata[11:0];
        CFG_OVERVOLT_RELEASE: cfg_nxt.overvolt_release     = cfg_wdata[11:0];
        CFG_OVERVOLT_LIMIT:   cfg_nxt.overvolt_count_limit = cfg_wdata[3:0];
        CFG_FUSE_HOLD:        cfg_nxt.fuse_hold_slots      = cfg_wdata[6:0];
        CFG_CUR_LOW:          cfg_nxt.current_limit_low    = cfg_wdata[11:0];
        CFG_CUR_MID:          cfg_nxt.current_limit_mid    = cfg_wdata[11:0];
        CFG_CUR_HIGH:         cfg_nxt.current_limit_high   = cfg_wdata[11:0];
        CFG_DUTY_CAP:         cfg_nxt.duty_cap_on          = cfg_wdata[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/fvr_step.sv =====
// fvr_step: one control tick of the regulator as combinational logic
// depends on fvr_pkg; takes current state, config and a request, gives next state and result

module fvr_step import fvr_pkg::*; (
  input  state_t    st,
  input  cfg_t      cfg,
  input  in_item_t  req,
  output state_t    st_nxt,
  output out_item_t res
);

  logic [5:0]  slot_sum;
  logic        trip;
  logic        do_nudge;
  logic [11:0] v;
  logic [11:0] cur;
  logic [7:0]  d;
  state_t      ns;

  always_comb begin
    ns       = st;
    trip     = 1'b0;
    do_nudge = 1'b0;
    v        = req.fan_voltage;
    cur      = req.out_current;

    slot_sum = {1'b0, st.slot_counter} + 6'd1;
    ns.slot_counter = (slot_sum > {1'b0, SLOT_PERIOD}) ? 5'd0 : slot_sum[4:0];

    if (req.key_press) begin
      ns.fan_mode = fan_mode_t'(st.fan_mode + 2'd1);
      if (ns.fan_mode == MODE_OFF) begin
        ns.duty_limit = 8'd0;
      end else begin
        ns.target_duty = start_duty(ns.fan_mode);
        ns.duty_limit  = cfg.duty_cap_on;
        ns.fan_on_reg  = 1'b1;
      end
      ns.no_load_count = 7'd0;
    end

    if (ns.fan_mode != MODE_OFF) begin
      // current limiting in the late slots
      if (ns.slot_counter >= CUR_SLOT_FIRST) begin
        if (cur > cfg.current_limit_low) begin
          if (ns.overcurrent_count != OC_MAX) begin
            ns.overcurrent_count = ns.overcurrent_count + 3'd1;
          end
          if (ns.overcurrent_count >= OC_FORCE) begin
            if (cur > cfg.current_limit_high) begin
              ns.target_duty = DUTY_OC_HIGH;
            end else if (cur > cfg.current_limit_mid) begin
              ns.target_duty = DUTY_OC_MID;
            end else begin
              ns.target_duty = ns.target_duty - 8'd3;
            end
          end
        end else begin
          ns.overcurrent_count = 3'd0;
        end
      end

      if (ns.target_duty > ns.duty_limit) begin
        ns.target_duty = ns.duty_limit;
      end

      // fuse and nudging in the early slots
      if (ns.slot_counter <= REG_SLOT_LAST) begin
        if (ns.hold_countdown != 7'd0) begin
          ns.hold_countdown = ns.hold_countdown - 7'd1;
          ns.target_duty    = 8'd0;
          if (v < cfg.overvolt_release) begin
            ns.hold_countdown = 7'd0;
          end
        end else if (v > cfg.overvolt_level) begin
          if (ns.overvolt_count != OV_MAX) begin
            ns.overvolt_count = ns.overvolt_count + 4'd1;
          end
          if (ns.overvolt_count >= cfg.overvolt_count_limit) begin
            ns.target_duty    = 8'd0;
            ns.overvolt_count = 4'd0;
            ns.hold_countdown = cfg.fuse_hold_slots;
            trip              = 1'b1;
          end else begin
            do_nudge = 1'b1;
          end
        end else begin
          ns.overvolt_count = 4'd0;
          do_nudge          = 1'b1;
        end
      end

      d = ns.target_duty;
      if (do_nudge && (v > V_LOW_GATE)) begin
        case (ns.fan_mode)
          MODE_LOW: begin
            if (v < V1_UP)       d = d + 8'd1;
            else if (v > V1_DN3) d = d - 8'd3;
            else if (v > V1_DN1) d = d - 8'd1;
          end
          MODE_MID: begin
            if (v < V2_UP)       d = d + 8'd1;
            else if (v > V2_DN3) d = d - 8'd3;
            else if (v > V2_DN1) d = d - 8'd1;
          end
          default: begin
            if (v < V3_UP)       d = d + 8'd1;
            else if (v > V3_DN4) d = d - 8'd4;
            else if (v > V3_DN2) d = d - 8'd2;
            else if (v > V3_DN1) d = d - 8'd1;
          end
        endcase
      end
      ns.target_duty = d;

      if (trip) begin
        if (ns.no_load_count != NL_MAX) begin
          ns.no_load_count = ns.no_load_count + 7'd1;
        end
        if (ns.no_load_count >= NO_LOAD_LIMIT) begin
          ns.fan_on_reg    = 1'b0;
          ns.duty_out_reg  = 8'd0;
          ns.no_load_count = 7'd0;
        end
      end else begin
        ns.fan_on_reg    = 1'b1;
        ns.no_load_count = 7'd0;
        ns.duty_out_reg  = ns.target_duty;
      end
    end else begin
      d               = ns.target_duty;
      ns.fan_on_reg   = 1'b0;
      ns.duty_out_reg = 8'd0;
    end

    st_nxt           = ns;
    res.mode_now     = ns.fan_mode;
    res.fan_enable   = ns.fan_on_reg;
    res.applied_duty = ns.duty_out_reg;
    res.fuse_trip    = trip;
  end

endmodule

// ===== hdl/fan_voltage_regulator_with_fuse_top.sv =====
// fan_voltage_regulator_with_fuse_top: top level of the fan voltage regulator
// depends on fvr_pkg, fvr_cfg and fvr_step

// Each request is one control tick (key click, fan voltage, output current) and gives
// exactly one result (mode, fan enable, applied duty, fuse trip). A request is captured
// in an input register; the tick logic then updates the regulator state and loads the
// result register once that register is empty or being taken, which raises
// out_valid. One request is taken every cycle while the result side keeps up; the rate
// rests on the combinational state update that each tick depends on. Configuration registers
// are written through cfg_we/cfg_index/cfg_wdata and must only change while no request is
// in flight.
module fan_voltage_regulator_with_fuse_top import fvr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_vld_r;
  logic      in_vld_nxt;
  state_t    st_r;
  state_t    st_nxt;
  out_item_t out_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t res;
  logic      advance;
  logic      fire;

  fvr_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fvr_step u_step (
    .st     (st_r),
    .cfg    (cfg),
    .req    (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // result register frees up when empty or being taken
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    if (in_ready) begin
      in_vld_nxt = in_valid;
    end
    if (advance) begin
      out_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= STATE_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
